FILE: rtl/core/sparse_dirichlet_condition_filter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse Dirichlet condition filter
// Shorthand for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_DIRICHLET_CONDITION_FILTER_CORE_ASSERT_SVH
`define SPARSE_DIRICHLET_CONDITION_FILTER_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds too
`define SDCF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle
`define SDCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/sdcf_pkg.sv
// ----------------------------------------------------------------------------
// sdcf_pkg
// Shared widths, codes and result word type of the condition filter.
// ----------------------------------------------------------------------------
package sdcf_pkg;

   localparam int ROW_W   = 10;
   localparam int VALUE_W = 32;
   localparam int SIZE_W  = 11;
   localparam int OP_W    = 3;
   localparam int KIND_W  = 2;
   localparam int ERR_W   = 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // 1.0 in Q16.16
   localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0001_0000;

   // Result buffer geometry
   localparam int RSP_DEPTH  = 8;
   localparam int RSP_PTR_W  = 3;
   localparam int RSP_CNT_W  = 4;
   localparam int RSP_CRED_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR      = 3'd0,
      OP_ADD_FIX    = 3'd1,
      OP_WRITE_LOAD = 3'd2,
      OP_ENTRY      = 3'd3,
      OP_READ_ROW   = 3'd4
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENTRY = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 2'd0,
      ERR_RANGE     = 2'd1,
      ERR_DUPLICATE = 2'd2,
      ERR_SATURATED = 2'd3
   } err_type;

   // What the second stage does with an item
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_ERROR,
      ACT_PASS,
      ACT_LOAD_WRITE,
      ACT_LOAD_UPDATE,
      ACT_READ_LOAD,
      ACT_READ_FIXED
   } action_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [ROW_W-1:0]          row;
      logic [ROW_W-1:0]          column;
      logic signed [VALUE_W-1:0] value;
      logic [ERR_W-1:0]          error_code;
      logic                      last;
   } rsp_word_type;

endpackage

FILE: rtl/core/sdcf_ram.sv
// ----------------------------------------------------------------------------
// sdcf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sdcf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the array, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sparse_dirichlet_condition_filter_core.sv
// ----------------------------------------------------------------------------
// sparse_dirichlet_condition_filter_core
// Applies fixed-displacement constraints to a stream of sparse stiffness
// entries and keeps the load vector up to date, in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_wr_en/csr_wr_data set the system size (reset 1024); write it only
//    while the block is idle.
//  - req_* carries one command word per accepted cycle: clear constraints,
//    add constraint, write load, stiffness entry, read row.
//  - rsp_* returns result words (kept entry, load value, error report);
//    rsp_last marks the final word of a command.
// Timing:
//  - Two pipeline stages, then an 8-word result buffer: a command passes
//    stage 1 and stage 2, and its result words go into the buffer for rsp_*.
//  - One command per cycle while req_stall is low. Loads live in one RAM and
//    constraint flags with prescribed values in another (kept twice to get
//    two read ports); a same-row update chain is forwarded, so it never waits.
//  - A clear command sweeps the constraint RAM: req_stall stays high from
//    when the clear reaches stage 1 until the sweep ends. After reset the
//    same sweep runs before the first command is taken.
//  - When rsp_stall holds results back, the buffer fills and req_stall rises
//    as soon as the free words cannot cover the commands in flight.
// ----------------------------------------------------------------------------
`include "sparse_dirichlet_condition_filter_core_assert.svh"

module sparse_dirichlet_condition_filter_core #(
   parameter int MAX_DOF = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [sdcf_pkg::SIZE_W-1:0]           csr_wr_data,
   // command words
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [sdcf_pkg::OP_W-1:0]             req_op,
   input  logic [sdcf_pkg::ROW_W-1:0]            req_row_index,
   input  logic [sdcf_pkg::ROW_W-1:0]            req_column_index,
   input  logic signed [sdcf_pkg::VALUE_W-1:0]   req_value,
   // result words
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sdcf_pkg::KIND_W-1:0]           rsp_kind,
   output logic [sdcf_pkg::ROW_W-1:0]            rsp_out_row,
   output logic [sdcf_pkg::ROW_W-1:0]            rsp_out_column,
   output logic signed [sdcf_pkg::VALUE_W-1:0]   rsp_out_value,
   output logic [sdcf_pkg::ERR_W-1:0]            rsp_error_code,
   output logic                                  rsp_last
);

   import sdcf_pkg::*;

   localparam int AW   = $clog2(MAX_DOF);
   localparam int CM_W = VALUE_W + 1;
   localparam logic [31:0]   MaxDofU   = 32'(MAX_DOF);
   localparam logic [AW-1:0] SweepLast = AW'(MAX_DOF - 1);

   // configuration
   logic [SIZE_W-1:0] system_size_ff;

   // stage 1
   logic                      s1_valid_ff;
   op_type                    s1_op_ff;
   logic [ROW_W-1:0]          s1_row_ff;
   logic [ROW_W-1:0]          s1_col_ff;
   logic signed [VALUE_W-1:0] s1_value_ff;

   // stage 2
   logic                      s2_valid_ff;
   action_type                s2_action_ff;
   action_type                s2_action_in;
   err_type                   s2_err_ff;
   err_type                   s2_err_in;
   logic [ROW_W-1:0]          s2_row_ff;
   logic [ROW_W-1:0]          s2_col_ff;
   logic signed [VALUE_W-1:0] s2_value_ff;
   logic signed [VALUE_W-1:0] s2_value_in;
   logic signed [63:0]        s2_prod_ff;
   logic signed [63:0]        s2_prod_in;
   logic [VALUE_W-1:0]        s2_base_ff;
   logic [VALUE_W-1:0]        s2_base_in;
   logic                      s2_cm_set_ff;
   logic                      s2_cm_set_in;

   // last load write, for forwarding
   logic                      lw_valid_ff;
   logic [ROW_W-1:0]          lw_addr_ff;
   logic [VALUE_W-1:0]        lw_data_ff;

   // clear sweep
   logic                      sweep_active_ff;
   logic                      sweep_active_in;
   logic [AW-1:0]             sweep_cnt_ff;
   logic [AW-1:0]             sweep_cnt_in;
   logic                      clear_in_s1;

   // memories
   logic                      cm_wr_en;
   logic [AW-1:0]             cm_wr_addr;
   logic [CM_W-1:0]           cm_wr_data;
   logic [CM_W-1:0]           cm_row_rd;
   logic [CM_W-1:0]           cm_col_rd;
   logic                      lm_wr_en;
   logic [VALUE_W-1:0]        lm_wr_data;
   logic [VALUE_W-1:0]        lm_rd;

   // stage 1 decode
   logic                      row_ok;
   logic                      col_ok;
   logic                      fwd_row;
   logic                      fwd_col;
   logic                      row_fixed;
   logic                      col_fixed;
   logic signed [VALUE_W-1:0] row_presc;
   logic signed [VALUE_W-1:0] col_presc;

   // stage 2 arithmetic
   logic [VALUE_W-1:0]        load_base2;
   logic [48:0]               upd_diff;
   logic                      upd_ovf;
   logic [VALUE_W-1:0]        upd_value;

   // result buffer
   rsp_word_type              fifo_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]      fifo_head_ff;
   logic [RSP_PTR_W-1:0]      fifo_head_in;
   logic [RSP_PTR_W-1:0]      fifo_tail_ff;
   logic [RSP_PTR_W-1:0]      fifo_tail_in;
   logic [RSP_CNT_W-1:0]      fifo_count_ff;
   logic [RSP_CNT_W-1:0]      fifo_count_in;
   rsp_word_type              push_word0;
   rsp_word_type              push_word1;
   logic [1:0]                push_n;
   logic                      pop;
   rsp_word_type              rsp_word;
   logic [RSP_CRED_W-1:0]     credit_need;
   logic                      req_accept;

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         system_size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         system_size_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Input handshake: hold off while a clear is in stage 1 or sweeping, or when results lack room
   // ------------------------------------------------------------------
   assign clear_in_s1 = s1_valid_ff && (s1_op_ff == OP_CLEAR);
   assign credit_need = RSP_CRED_W'(fifo_count_ff)
                      + RSP_CRED_W'({s1_valid_ff, 1'b0})
                      + RSP_CRED_W'({s2_valid_ff, 1'b0})
                      + RSP_CRED_W'(2);
   assign req_stall   = sweep_active_ff || clear_in_s1
                      || (credit_need > RSP_CRED_W'(RSP_DEPTH));
   assign req_accept  = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Stage 1 registers; the RAMs read at the accepted word's indices
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= op_type'(req_op);
      s1_row_ff   <= req_row_index;
      s1_col_ff   <= req_column_index;
      s1_value_ff <= req_value;
   end

   // Constraint flag + prescribed value, one copy per read index
   sdcf_ram #(.WIDTH(CM_W), .DEPTH(MAX_DOF)) u_cm_row (
      .clock   (clock),
      .wr_en   (cm_wr_en),
      .wr_addr (cm_wr_addr),
      .wr_data (cm_wr_data),
      .rd_addr (AW'(req_row_index)),
      .rd_data (cm_row_rd)
   );

   sdcf_ram #(.WIDTH(CM_W), .DEPTH(MAX_DOF)) u_cm_col (
      .clock   (clock),
      .wr_en   (cm_wr_en),
      .wr_addr (cm_wr_addr),
      .wr_data (cm_wr_data),
      .rd_addr (AW'(req_column_index)),
      .rd_data (cm_col_rd)
   );

   // Load vector
   sdcf_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DOF)) u_load (
      .clock   (clock),
      .wr_en   (lm_wr_en),
      .wr_addr (AW'(s2_row_ff)),
      .wr_data (lm_wr_data),
      .rd_addr (AW'(req_row_index)),
      .rd_data (lm_rd)
   );

   // ------------------------------------------------------------------
   // Stage 1: range checks, constraint lookup with forwarding
   // ------------------------------------------------------------------
   assign row_ok = (SIZE_W'(s1_row_ff) < system_size_ff) && (32'(s1_row_ff) < MaxDofU);
   assign col_ok = (SIZE_W'(s1_col_ff) < system_size_ff) && (32'(s1_col_ff) < MaxDofU);

   // A constraint added by the word just ahead is not yet in the read data
   assign fwd_row   = s2_cm_set_ff && (s2_row_ff == s1_row_ff);
   assign fwd_col   = s2_cm_set_ff && (s2_row_ff == s1_col_ff);
   assign row_fixed = fwd_row ? 1'b1 : cm_row_rd[VALUE_W];
   assign col_fixed = fwd_col ? 1'b1 : cm_col_rd[VALUE_W];
   assign row_presc = fwd_row ? s2_value_ff : cm_row_rd[VALUE_W-1:0];
   assign col_presc = fwd_col ? s2_value_ff : cm_col_rd[VALUE_W-1:0];

   // Load written two words ahead landed after this word's read
   assign s2_base_in = (lw_valid_ff && (lw_addr_ff == s1_row_ff)) ? lw_data_ff : lm_rd;

   // Coupling product, exact Q32.32
   assign s2_prod_in = s1_value_ff * col_presc;

   // Decide what stage 2 does
   always_comb begin
      s2_action_in = ACT_NONE;
      s2_err_in    = ERR_NONE;
      s2_value_in  = s1_value_ff;
      s2_cm_set_in = 1'b0;
      if (s1_valid_ff) begin
         unique case (s1_op_ff)
            OP_CLEAR: begin
               s2_action_in = ACT_NONE;
            end
            OP_ADD_FIX: begin
               if (!row_ok) begin
                  s2_action_in = ACT_ERROR;
                  s2_err_in    = ERR_RANGE;
               end else if (row_fixed) begin
                  s2_action_in = ACT_ERROR;
                  s2_err_in    = ERR_DUPLICATE;
               end else begin
                  s2_cm_set_in = 1'b1;
               end
            end
            OP_WRITE_LOAD: begin
               if (!row_ok) begin
                  s2_action_in = ACT_ERROR;
                  s2_err_in    = ERR_RANGE;
               end else begin
                  s2_action_in = ACT_LOAD_WRITE;
               end
            end
            OP_ENTRY: begin
               if (!row_ok || !col_ok) begin
                  s2_action_in = ACT_ERROR;
                  s2_err_in    = ERR_RANGE;
               end else if (row_fixed) begin
                  s2_action_in = ACT_NONE;
               end else if (!col_fixed) begin
                  s2_action_in = ACT_PASS;
               end else begin
                  s2_action_in = ACT_LOAD_UPDATE;
               end
            end
            OP_READ_ROW: begin
               if (!row_ok) begin
                  s2_action_in = ACT_ERROR;
                  s2_err_in    = ERR_RANGE;
               end else if (row_fixed) begin
                  s2_action_in = ACT_READ_FIXED;
                  s2_value_in  = row_presc;
               end else begin
                  s2_action_in = ACT_READ_LOAD;
               end
            end
            default: begin
               s2_action_in = ACT_NONE;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Clear sweep: reset and the clear command walk the constraint RAM
   // ------------------------------------------------------------------
   always_comb begin
      sweep_active_in = sweep_active_ff;
      sweep_cnt_in    = sweep_cnt_ff;
      if (clear_in_s1) begin
         sweep_active_in = 1'b1;
         sweep_cnt_in    = '0;
      end else if (sweep_active_ff) begin
         sweep_cnt_in = sweep_cnt_ff + AW'(1);
         if (sweep_cnt_ff == SweepLast) begin
            sweep_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_active_ff <= 1'b1;
         sweep_cnt_ff    <= '0;
      end else begin
         sweep_active_ff <= sweep_active_in;
         sweep_cnt_ff    <= sweep_cnt_in;
      end
   end

   // Constraint RAM write: sweep clears, stage 1 marks a new constraint
   assign cm_wr_en   = sweep_active_ff || s2_cm_set_in;
   assign cm_wr_addr = sweep_active_ff ? sweep_cnt_ff : AW'(s1_row_ff);
   assign cm_wr_data = sweep_active_ff ? '0 : {1'b1, s1_value_ff};

   // ------------------------------------------------------------------
   // Stage 2 registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s2_action_ff <= ACT_NONE;
         s2_cm_set_ff <= 1'b0;
         lw_valid_ff  <= 1'b0;
      end else begin
         s2_valid_ff  <= s1_valid_ff;
         s2_action_ff <= s2_action_in;
         s2_cm_set_ff <= s2_cm_set_in;
         lw_valid_ff  <= lm_wr_en;
      end
   end

   always_ff @(posedge clock) begin
      s2_err_ff   <= s2_err_in;
      s2_row_ff   <= s1_row_ff;
      s2_col_ff   <= s1_col_ff;
      s2_value_ff <= s2_value_in;
      s2_prod_ff  <= s2_prod_in;
      s2_base_ff  <= s2_base_in;
      lw_addr_ff  <= s2_row_ff;
      lw_data_ff  <= lm_wr_data;
   end

   // ------------------------------------------------------------------
   // Stage 2: load update with rounding and saturation
   // ------------------------------------------------------------------
   // Load written by the word just ahead overrides the stage 1 value
   assign load_base2 = (lw_valid_ff && (lw_addr_ff == s2_row_ff)) ? lw_data_ff : s2_base_ff;

   // load - floor((p + 2^15) / 2^16) = load + ~p[63:16] + !p[15]
   assign upd_diff  = {{17{load_base2[VALUE_W-1]}}, load_base2}
                    + ~{s2_prod_ff[63], s2_prod_ff[63:16]}
                    + {48'b0, !s2_prod_ff[15]};
   assign upd_ovf   = (upd_diff[48:31] != {18{upd_diff[48]}});
   assign upd_value = upd_ovf ? (upd_diff[48] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                              : upd_diff[VALUE_W-1:0];

   // Load writes and result words
   always_comb begin
      lm_wr_en              = 1'b0;
      lm_wr_data            = s2_value_ff;
      push_n                = 2'd0;
      push_word0.kind       = KIND_ENTRY;
      push_word0.row        = s2_row_ff;
      push_word0.column     = s2_col_ff;
      push_word0.value      = s2_value_ff;
      push_word0.error_code = ERR_NONE;
      push_word0.last       = 1'b1;
      push_word1.kind       = KIND_ENTRY;
      push_word1.row        = s2_row_ff;
      push_word1.column     = s2_row_ff;
      push_word1.value      = Q_ONE;
      push_word1.error_code = ERR_NONE;
      push_word1.last       = 1'b1;
      unique case (s2_action_ff)
         ACT_ERROR: begin
            push_n                = 2'd1;
            push_word0.kind       = KIND_ERROR;
            push_word0.value      = '0;
            push_word0.error_code = s2_err_ff;
         end
         ACT_PASS: begin
            push_n = 2'd1;
         end
         ACT_LOAD_WRITE: begin
            lm_wr_en = 1'b1;
         end
         ACT_LOAD_UPDATE: begin
            lm_wr_en   = 1'b1;
            lm_wr_data = upd_value;
            if (upd_ovf) begin
               push_n                = 2'd1;
               push_word0.kind       = KIND_ERROR;
               push_word0.value      = '0;
               push_word0.error_code = ERR_SATURATED;
            end
         end
         ACT_READ_LOAD: begin
            push_n            = 2'd1;
            push_word0.kind   = KIND_LOAD;
            push_word0.column = '0;
            push_word0.value  = load_base2;
         end
         ACT_READ_FIXED: begin
            push_n            = 2'd2;
            push_word0.kind   = KIND_LOAD;
            push_word0.column = '0;
            push_word0.last   = 1'b0;
         end
         default: begin
            push_n = 2'd0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Result buffer: up to two words in, and while rsp_stall is low one word out per cycle
   // ------------------------------------------------------------------
   assign pop = rsp_valid && !rsp_stall;

   assign fifo_head_in  = fifo_head_ff + RSP_PTR_W'(pop);
   assign fifo_tail_in  = fifo_tail_ff + RSP_PTR_W'(push_n);
   assign fifo_count_in = fifo_count_ff + RSP_CNT_W'(push_n) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_head_ff  <= '0;
         fifo_tail_ff  <= '0;
         fifo_count_ff <= '0;
      end else begin
         fifo_head_ff  <= fifo_head_in;
         fifo_tail_ff  <= fifo_tail_in;
         fifo_count_ff <= fifo_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_mem_ff[fifo_tail_ff] <= push_word0;
      end
      if (push_n == 2'd2) begin
         fifo_mem_ff[fifo_tail_ff + RSP_PTR_W'(1)] <= push_word1;
      end
   end

   assign rsp_word       = fifo_mem_ff[fifo_head_ff];
   assign rsp_valid      = (fifo_count_ff != '0);
   assign rsp_kind       = rsp_word.kind;
   assign rsp_out_row    = rsp_word.row;
   assign rsp_out_column = rsp_word.column;
   assign rsp_out_value  = rsp_word.value;
   assign rsp_error_code = rsp_word.error_code;
   assign rsp_last       = rsp_word.last;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `SDCF_ASSERT_IMPLY(a_result_room, clock, reset, s2_valid_ff, fifo_count_ff <= RSP_CNT_W'(RSP_DEPTH - 2), "result buffer lacks room for a word in stage 2")
   `SDCF_ASSERT_IMPLY(a_no_accept_in_sweep, clock, reset, sweep_active_ff, !(req_valid && !req_stall), "command accepted during constraint sweep")
   `SDCF_ASSERT_IMPLY(a_no_write_clash, clock, reset, sweep_active_ff, !s2_cm_set_in, "constraint write collides with sweep")
   `SDCF_ASSERT_NEXT(a_clear_starts_sweep, clock, reset, clear_in_s1, sweep_active_ff && (sweep_cnt_ff == '0), "clear command did not start the sweep")
   `SDCF_ASSERT_NEXT(a_diag_follows, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid, "unit diagonal word missing after prescribed value")

endmodule

FILE: tb/sparse_dirichlet_condition_filter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_dirichlet_condition_filter_core_test
// Self-checking bench for the constraint filter. A queue of command words
// feeds a clocked driver. Each accepted command runs through a local Q16.16
// model of the constraint map and load vector. The resulting words are
// matched in order by a clocked monitor with random stalls. Phases cover
// several system sizes, bursts and one long output hold-off.
// ----------------------------------------------------------------------------
module sparse_dirichlet_condition_filter_core_test;
   import sdcf_pkg::*;

   localparam int DOF = 1024;
   localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam logic signed [63:0] LOAD_MAX = 64'sd2147483647;
   localparam logic signed [63:0] LOAD_MIN = -64'sd2147483648;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic [ROW_W-1:0]          row;
      logic [ROW_W-1:0]          column;
      logic signed [VALUE_W-1:0] value;
   } command_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic [SIZE_W-1:0]           csr_wr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [OP_W-1:0]             req_op = '0;
   logic [ROW_W-1:0]            req_row_index = '0;
   logic [ROW_W-1:0]            req_column_index = '0;
   logic signed [VALUE_W-1:0]   req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [KIND_W-1:0]           rsp_kind;
   logic [ROW_W-1:0]            rsp_out_row;
   logic [ROW_W-1:0]            rsp_out_column;
   logic signed [VALUE_W-1:0]   rsp_out_value;
   logic [ERR_W-1:0]            rsp_error_code;
   logic                        rsp_last;

   sparse_dirichlet_condition_filter_core #(.MAX_DOF(DOF)) uut (.*);

   always #5 clock = ~clock;

   // Model state: size register, constraint map, prescribed values, loads
   logic [SIZE_W-1:0]         system_size = SIZE_RESET;
   bit                        fixed_map [DOF];
   logic signed [VALUE_W-1:0] fixed_value [DOF];
   logic signed [VALUE_W-1:0] load_value [DOF];
   rsp_word_type              expected_words [$];
   command_type               command_queue [$];

   // Stimulus bookkeeping
   bit          load_written [DOF];
   int unsigned active_dofs = DOF;
   int unsigned window_lo = 0;
   int unsigned window_hi = 31;
   int          fail_count = 0;
   bit          no_idle = 1'b0;
   bit          pressure_armed = 1'b0;

   function automatic logic [3:0] idle_draw();
      return no_idle ? 4'd0 : 4'($urandom_range(0, 15));
   endfunction

   // Update the model for one accepted command and queue its result words
   task automatic apply_command(input command_type c);
      int unsigned n;
      bit row_ok;
      bit col_ok;
      logic signed [63:0] lhs;
      logic signed [63:0] rhs;
      logic signed [63:0] rounded;
      logic signed [63:0] next_load;
      rsp_word_type w;
      n = (system_size < DOF) ? system_size : DOF;
      row_ok = c.row < n;
      col_ok = c.column < n;
      w = '{kind: KIND_ERROR, row: c.row, column: c.column, value: '0,
            error_code: ERR_RANGE, last: 1'b1};
      case (c.op)
         OP_CLEAR: begin
            foreach (fixed_map[i]) fixed_map[i] = 1'b0;
         end
         OP_ADD_FIX: begin
            if (!row_ok) begin
               expected_words.push_back(w);
            end else if (fixed_map[c.row]) begin
               w.error_code = ERR_DUPLICATE;
               expected_words.push_back(w);
            end else begin
               fixed_map[c.row] = 1'b1;
               fixed_value[c.row] = c.value;
            end
         end
         OP_WRITE_LOAD: begin
            if (!row_ok) expected_words.push_back(w);
            else load_value[c.row] = c.value;
         end
         OP_ENTRY: begin
            if (!row_ok || !col_ok) begin
               expected_words.push_back(w);
            end else if (!fixed_map[c.row] && !fixed_map[c.column]) begin
               w.kind = KIND_ENTRY;
               w.value = c.value;
               w.error_code = ERR_NONE;
               expected_words.push_back(w);
            end else if (!fixed_map[c.row]) begin
               // Move value * prescribed to the load side, round half up
               lhs = c.value;
               rhs = fixed_value[c.column];
               rounded = (lhs * rhs + 64'sd32768) >>> 16;
               next_load = load_value[c.row] - rounded;
               if (next_load > LOAD_MAX || next_load < LOAD_MIN) begin
                  load_value[c.row] = (next_load > 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                  w.error_code = ERR_SATURATED;
                  expected_words.push_back(w);
               end else begin
                  load_value[c.row] = next_load[31:0];
               end
            end
         end
         OP_READ_ROW: begin
            if (!row_ok) begin
               expected_words.push_back(w);
            end else begin
               w.kind = KIND_LOAD;
               w.column = '0;
               w.error_code = ERR_NONE;
               if (fixed_map[c.row]) begin
                  // Prescribed value, then the unit diagonal
                  w.value = fixed_value[c.row];
                  w.last = 1'b0;
                  expected_words.push_back(w);
                  w.kind = KIND_ENTRY;
                  w.column = c.row;
                  w.value = Q_ONE;
                  w.last = 1'b1;
               end else begin
                  w.value = load_value[c.row];
               end
               expected_words.push_back(w);
            end
         end
         default: ;
      endcase
   endtask

   // Driver: offer queued command words, idle a random gap (maybe none) between them
   logic [3:0] req_gap = '0;

   always @(posedge clock) begin : drive_proc
      command_type c;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_command(command_type'{req_op, req_row_index, req_column_index, req_value});
         end
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap <= req_gap - 4'd1;
            end else if (command_queue.size() != 0) begin
               c = command_queue.pop_front();
               req_op <= c.op;
               req_row_index <= c.row;
               req_column_index <= c.column;
               req_value <= c.value;
               req_valid <= 1'b1;
               req_gap <= idle_draw();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: match result words in order, stall at random
   logic [3:0] rsp_wait = '0;
   int         hold_left = 0;
   bit         pressure_done = 1'b0;

   always @(posedge clock) begin : monitor_proc
      rsp_word_type w;
      logic [3:0] next_wait;
      int next_hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait <= '0;
         hold_left <= 0;
      end else begin
         next_wait = (rsp_wait != 0) ? rsp_wait - 4'd1 : 4'd0;
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: kind %0d row %0d column %0d",
                      rsp_kind, rsp_out_row, rsp_out_column);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               check_field("kind", w.kind, rsp_kind);
               check_field("out_row", w.row, rsp_out_row);
               check_field("out_column", w.column, rsp_out_column);
               check_field("out_value", w.value, rsp_out_value);
               check_field("error_code", w.error_code, rsp_error_code);
               check_field("last", w.last, rsp_last);
            end
            next_wait = idle_draw();
         end
         // Hold off once for a long stretch so the block backs up
         next_hold = (hold_left > 0) ? hold_left - 1 : 0;
         if (pressure_armed && !pressure_done) begin
            next_hold = HOLD_OFF_CYCLES;
            pressure_done = 1'b1;
         end
         hold_left <= next_hold;
         rsp_wait <= next_wait;
         rsp_stall <= (next_wait != 0) || (next_hold != 0);
      end
   end

   task automatic queue_command(input logic [OP_W-1:0] op, input int unsigned row,
                                input int unsigned column, input logic signed [31:0] value);
      if (op == OP_WRITE_LOAD && row < active_dofs) load_written[row] = 1'b1;
      command_queue.push_back(command_type'{op, row[ROW_W-1:0], column[ROW_W-1:0], value});
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3, 4: return $urandom();
         default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      endcase
   endfunction

   // Mostly inside the working window so constraints get hit
   function automatic int unsigned random_index();
      if ($urandom_range(0, 99) < 85) return $urandom_range(window_lo, window_hi);
      return $urandom_range(0, DOF - 1);
   endfunction

   task automatic run_random(input int unsigned count);
      int unsigned done;
      int unsigned pick;
      int unsigned row;
      logic [OP_W-1:0] op;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         row = random_index();
         if (pick < 2) op = OP_CLEAR;
         else if (pick < 17) op = OP_ADD_FIX;
         else if (pick < 32) op = OP_WRITE_LOAD;
         else if (pick < 77) op = OP_ENTRY;
         else if (pick < 95) op = OP_READ_ROW;
         else op = OP_RESERVED_FIRST + 3'($urandom_range(0, 2));
         // Write a load before anything reads it
         if ((op == OP_ENTRY || op == OP_READ_ROW) && row < active_dofs && !load_written[row])
            op = OP_WRITE_LOAD;
         queue_command(op, row, random_index(), random_value());
         if (op < OP_RESERVED_FIRST) done++;
      end
   endtask

   // Wait for the block to drain and sit quiet
   task automatic wait_idle();
      do @(negedge clock);
      while (command_queue.size() != 0 || req_valid !== 1'b0 ||
             expected_words.size() != 0 || req_stall !== 1'b0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_phase(input logic [SIZE_W-1:0] size, input int unsigned lo,
                            input int unsigned width);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= size;
      system_size = size;
      active_dofs = (size < DOF) ? size : DOF;
      window_lo = lo;
      window_hi = (lo + width - 1 < DOF) ? lo + width - 1 : DOF - 1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : main_proc
      int unsigned n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, saturation both ways, rounding at one half
      set_phase(SIZE_RESET, 0, 32);
      queue_command(OP_WRITE_LOAD, 0, 0, 32'sh7FFF_FFFF);
      queue_command(OP_WRITE_LOAD, 1, 1023, 32'sh8000_0000);
      queue_command(OP_WRITE_LOAD, 1023, 0, 32'sh0);
      queue_command(OP_ADD_FIX, 1023, 0, 32'sh7FFF_FFFF);
      queue_command(OP_ADD_FIX, 1023, 1023, 32'sh5);
      queue_command(OP_ADD_FIX, 2, 0, 32'sh8000_0000);
      queue_command(OP_ENTRY, 0, 1023, 32'sh7FFF_FFFF);
      queue_command(OP_ENTRY, 1, 2, 32'sh7FFF_FFFF);
      queue_command(OP_ENTRY, 0, 1, 32'sh8000_0000);
      queue_command(OP_ENTRY, 1023, 0, 32'sh5);
      queue_command(OP_ENTRY, 1023, 1023, 32'sh7);
      queue_command(OP_WRITE_LOAD, 3, 0, 32'sh0001_8000);
      queue_command(OP_ADD_FIX, 4, 0, 32'sh0000_8000);
      queue_command(OP_ENTRY, 3, 4, 32'sh1);
      queue_command(OP_ENTRY, 3, 4, -32'sh1);
      queue_command(OP_READ_ROW, 0, 0, 32'sh0);
      queue_command(OP_READ_ROW, 1, 0, 32'sh0);
      queue_command(OP_READ_ROW, 3, 0, 32'sh0);
      queue_command(OP_READ_ROW, 1023, 0, 32'sh0);
      queue_command(OP_READ_ROW, 2, 1023, 32'sh0);
      queue_command(OP_RESERVED_FIRST, 0, 0, 32'sh0);
      queue_command(OP_RESERVED_FIRST + 3'd1, 1023, 1023, 32'sh7FFF_FFFF);
      queue_command(OP_RESERVED_FIRST + 3'd2, 5, 5, 32'sh8000_0000);
      queue_command(OP_CLEAR, 0, 0, 32'sh0);
      queue_command(OP_READ_ROW, 1023, 0, 32'sh0);
      queue_command(OP_ENTRY, 3, 4, 32'sh0002_0000);

      // Full size, low window
      set_phase(SIZE_RESET, 0, 32);
      run_random(150);

      // Full size, top window, back-to-back words against a long hold-off
      set_phase(SIZE_RESET, DOF - 32, 32);
      no_idle = 1'b1;
      pressure_armed = 1'b1;
      run_random(100);
      wait_idle();
      no_idle = 1'b0;

      // Size one: only index 0 is in range
      set_phase(11'd1, 0, 1);
      run_random(40);

      // Oversized register clamps to the full system
      set_phase(11'h7FF, 500, 32);
      run_random(100);

      // Zero size: every index out of range
      set_phase(11'd0, 0, 1);
      run_random(15);

      // Random size
      n = $urandom_range(2, DOF - 1);
      set_phase(n[SIZE_W-1:0], 0, (n < 24) ? n : 24);
      run_random(100);

      wait_idle();
      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Give up if the block hangs
   initial begin : timeout_proc
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/sdcf_pkg.sv
rtl/core/sdcf_ram.sv
rtl/core/sparse_dirichlet_condition_filter_core.sv
tb/sparse_dirichlet_condition_filter_core_test.sv
